>>> src/drag_scroll_pointer_processor_macros.svh
// assertion macros for the drag-scroll pointer processor
// included by modules that carry concurrent checks; no other dependencies
`ifndef DRAG_SCROLL_POINTER_PROCESSOR_MACROS_SVH
`define DRAG_SCROLL_POINTER_PROCESSOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dsp_pkg.sv
// shared types, codes and constants of the drag-scroll pointer processor
// no dependencies; used by every module of the block but the divider
`default_nettype none

package dsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CPI_W         = 14;
  localparam int DIV_W         = 5;
  localparam int PIX_W         = 8;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [CPI_W-1:0] CPI_MIN_RST = 14'd200;
  localparam logic [CPI_W-1:0] CPI_MAX_RST = 14'd12000;
  localparam logic [CPI_W-1:0] CPI_DEF_RST = 14'd400;

  localparam logic [DIV_W-1:0] DIV_DEF_RST = 5'd5;
  localparam logic [DIV_W-1:0] DIV_LO      = 5'd1;
  localparam logic [DIV_W-1:0] DIV_HI      = 5'd20;

  // cpi tiers, one bit wider than the cpi so a step up cannot wrap
  localparam logic [CPI_W:0] CPI_TIER_HI  = 15'd5000;
  localparam logic [CPI_W:0] CPI_TIER_MID = 15'd1500;
  localparam logic [CPI_W:0] CPI_STEP_HI  = 15'd1000;
  localparam logic [CPI_W:0] CPI_STEP_MID = 15'd500;
  localparam logic [CPI_W:0] CPI_STEP_LO  = 15'd200;

  localparam logic MODE_MOTION = 1'b0;
  localparam logic MODE_KEY    = 1'b1;

  typedef enum logic [2:0] {
    KEY_CPI_UP,
    KEY_CPI_DOWN,
    KEY_CPI_DEF,
    KEY_DRAG,
    KEY_SCROLL_UP,
    KEY_SCROLL_DOWN,
    KEY_SCROLL_DEF,
    KEY_INVERT
  } dsp_key_t;

  typedef enum logic [1:0] {
    REG_CPI_MIN,
    REG_CPI_MAX,
    REG_CPI_DEF,
    REG_DIV_DEF
  } dsp_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SUM,
    S_WB
  } dsp_state_t;

  typedef struct packed {
    logic                    mode;
    dsp_key_t                key;
    logic                    pressed;
    logic signed [PIX_W-1:0] x_in;
    logic signed [PIX_W-1:0] y_in;
    logic signed [PIX_W-1:0] h_in;
    logic signed [PIX_W-1:0] v_in;
  } dsp_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] x_out;
    logic signed [PIX_W-1:0] y_out;
    logic signed [PIX_W-1:0] h_out;
    logic signed [PIX_W-1:0] v_out;
    logic [CPI_W-1:0]        cpi_now;
    logic                    cpi_write;
  } dsp_out_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic sum_en;
    logic wb_en;
  } dsp_cmd_t;

  typedef struct packed {
    logic in_is_key;
    logic drag;
    logic div_done;
  } dsp_sts_t;

  typedef struct packed {
    logic              wr_en;
    dsp_reg_t          idx;
    logic [DATA_W-1:0] wdata;
  } dsp_cfg_t;

  function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] d);
    if (d < DIV_LO) return DIV_LO;
    if (d > DIV_HI) return DIV_HI;
    return d;
  endfunction

endpackage

`default_nettype wire

>>> src/dsp_div.sv
// serial restoring divider, one quotient bit per cycle
// unsigned dividend over a narrow unsigned divisor; no package dependency
`default_nettype none

module dsp_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  busy,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

`default_nettype wire

>>> src/dsp_datapath.sv
// datapath: config registers, cpi/divisor state, drag accumulators, result register
// depends on dsp_pkg, dsp_div and the assertion macro header
`default_nettype none
`include "drag_scroll_pointer_processor_macros.svh"

module dsp_datapath #(
  parameter int FRAC_BITS = dsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dsp_pkg::dsp_cmd_t           cmd,
  output dsp_pkg::dsp_sts_t                sts,
  input  wire dsp_pkg::dsp_in_t            in_data,
  output dsp_pkg::dsp_out_t                out_data,
  input  wire dsp_pkg::dsp_cfg_t           cfg,
  input  wire dsp_pkg::dsp_reg_t           cfg_raddr,
  output logic [dsp_pkg::DATA_W-1:0]       cfg_rdata
);

  localparam int NUM_W = FRAC_BITS + dsp_pkg::PIX_W;
  localparam int AW    = NUM_W + 1;
  localparam int IP_W  = AW - FRAC_BITS;

  logic [dsp_pkg::CPI_W-1:0] cpi_min_r, cpi_max_r, cpi_def_r;
  logic [dsp_pkg::DIV_W-1:0] div_def_r;
  logic [dsp_pkg::CPI_W-1:0] cpi_r, cpi_nxt;
  logic [dsp_pkg::DIV_W-1:0] div_r, div_nxt;
  logic                      inv_r, inv_nxt;
  logic                      drag_r, drag_nxt;
  logic [AW-1:0]             acc_h_r, acc_h_nxt, acc_v_r, acc_v_nxt;
  logic [AW-1:0]             sum_h_r, sum_h_nxt, sum_v_r, sum_v_nxt;
  dsp_pkg::dsp_in_t          item_r;
  dsp_pkg::dsp_out_t         out_r, out_nxt;

  logic [NUM_W-1:0]          q_h, q_v;
  logic                      busy_h, busy_v;
  logic [dsp_pkg::CPI_W:0]   cpi_ext, step, cpi_stepped, cpi_clamped;
  logic [AW-1:0]             mag_h, mag_v;
  logic                      neg_h, neg_v;

  function automatic logic [dsp_pkg::PIX_W-1:0] abs_pix(input logic [dsp_pkg::PIX_W-1:0] p);
    return p[dsp_pkg::PIX_W-1] ? (-p) : p;
  endfunction

  function automatic logic [dsp_pkg::PIX_W-1:0] wheel_val(input logic [IP_W-1:0] ip_mag,
                                                          input logic neg);
    logic [dsp_pkg::PIX_W-1:0] sat;
    sat = (ip_mag > IP_W'(127)) ? 8'd127 : {1'b0, ip_mag[6:0]};
    return neg ? (-sat) : sat;
  endfunction

  function automatic logic [AW-1:0] keep_frac(input logic [AW-1:0] mag, input logic neg);
    logic [AW-1:0] f;
    f = {{IP_W{1'b0}}, mag[FRAC_BITS-1:0]};
    return neg ? (-f) : f;
  endfunction

  // two dividers, x and y run side by side
  dsp_div #(.NUM_W(NUM_W), .DEN_W(dsp_pkg::DIV_W)) u_div_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend ({abs_pix(in_data.x_in), {FRAC_BITS{1'b0}}}),
    .divisor  (div_r),
    .busy     (busy_h),
    .quotient (q_h)
  );

  dsp_div #(.NUM_W(NUM_W), .DEN_W(dsp_pkg::DIV_W)) u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend ({abs_pix(in_data.y_in), {FRAC_BITS{1'b0}}}),
    .divisor  (div_r),
    .busy     (busy_v),
    .quotient (q_v)
  );

  assign sts.in_is_key = (in_data.mode == dsp_pkg::MODE_KEY);
  assign sts.drag      = drag_r;
  assign sts.div_done  = !busy_h && !busy_v;
  assign out_data      = out_r;

  // signed add of the truncated increment
  assign sum_h_nxt = item_r.x_in[dsp_pkg::PIX_W-1] ? (acc_h_r - {1'b0, q_h})
                                                   : (acc_h_r + {1'b0, q_h});
  assign sum_v_nxt = item_r.y_in[dsp_pkg::PIX_W-1] ? (acc_v_r - {1'b0, q_v})
                                                   : (acc_v_r + {1'b0, q_v});

  // tiered cpi step and clamp
  always_comb begin
    cpi_ext = {1'b0, cpi_r};
    if (cpi_ext > dsp_pkg::CPI_TIER_HI) begin
      step = dsp_pkg::CPI_STEP_HI;
    end else if (cpi_ext > dsp_pkg::CPI_TIER_MID) begin
      step = dsp_pkg::CPI_STEP_MID;
    end else begin
      step = dsp_pkg::CPI_STEP_LO;
    end
    if (item_r.key == dsp_pkg::KEY_CPI_UP) begin
      cpi_stepped = cpi_ext + step;
    end else if (cpi_ext > step) begin
      cpi_stepped = cpi_ext - step;
    end else begin
      cpi_stepped = cpi_ext;
    end
    cpi_clamped = cpi_stepped;
    if (cpi_clamped < {1'b0, cpi_min_r}) cpi_clamped = {1'b0, cpi_min_r};
    if (cpi_clamped > {1'b0, cpi_max_r}) cpi_clamped = {1'b0, cpi_max_r};
  end

  // write-back of one item
  always_comb begin
    mag_h     = sum_h_r[AW-1] ? (-sum_h_r) : sum_h_r;
    mag_v     = sum_v_r[AW-1] ? (-sum_v_r) : sum_v_r;
    neg_h     = sum_h_r[AW-1];
    neg_v     = sum_v_r[AW-1];
    cpi_nxt   = cpi_r;
    div_nxt   = div_r;
    inv_nxt   = inv_r;
    drag_nxt  = drag_r;
    acc_h_nxt = acc_h_r;
    acc_v_nxt = acc_v_r;
    out_nxt   = '0;
    if (item_r.mode == dsp_pkg::MODE_KEY) begin
      unique case (item_r.key) inside
        dsp_pkg::KEY_CPI_UP, dsp_pkg::KEY_CPI_DOWN: begin
          if (item_r.pressed) begin
            cpi_nxt           = cpi_clamped[dsp_pkg::CPI_W-1:0];
            out_nxt.cpi_write = 1'b1;
          end
        end
        dsp_pkg::KEY_CPI_DEF: begin
          if (item_r.pressed) begin
            cpi_nxt           = cpi_def_r;
            out_nxt.cpi_write = 1'b1;
          end
        end
        dsp_pkg::KEY_DRAG: begin
          drag_nxt = item_r.pressed;
        end
        dsp_pkg::KEY_SCROLL_UP: begin
          if (item_r.pressed && div_r > dsp_pkg::DIV_LO) div_nxt = div_r - 1'b1;
        end
        dsp_pkg::KEY_SCROLL_DOWN: begin
          if (item_r.pressed) div_nxt = dsp_pkg::clamp_div(div_r + 1'b1);
        end
        dsp_pkg::KEY_SCROLL_DEF: begin
          if (item_r.pressed) div_nxt = dsp_pkg::clamp_div(div_def_r);
        end
        dsp_pkg::KEY_INVERT: begin
          if (item_r.pressed) inv_nxt = !inv_r;
        end
      endcase
    end else if (drag_r) begin
      acc_h_nxt     = keep_frac(mag_h, neg_h);
      acc_v_nxt     = keep_frac(mag_v, neg_v);
      out_nxt.h_out = wheel_val(mag_h[AW-1:FRAC_BITS], neg_h);
      out_nxt.v_out = wheel_val(mag_v[AW-1:FRAC_BITS], neg_v ^ inv_r);
    end else begin
      out_nxt.x_out = item_r.x_in;
      out_nxt.y_out = item_r.y_in;
      out_nxt.h_out = item_r.h_in;
      out_nxt.v_out = item_r.v_in;
    end
    out_nxt.cpi_now = cpi_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpi_min_r <= dsp_pkg::CPI_MIN_RST;
      cpi_max_r <= dsp_pkg::CPI_MAX_RST;
      cpi_def_r <= dsp_pkg::CPI_DEF_RST;
      div_def_r <= dsp_pkg::DIV_DEF_RST;
      cpi_r     <= dsp_pkg::CPI_DEF_RST;
      div_r     <= dsp_pkg::clamp_div(dsp_pkg::DIV_DEF_RST);
      inv_r     <= 1'b1;
      drag_r    <= 1'b0;
      acc_h_r   <= '0;
      acc_v_r   <= '0;
    end else begin
      if (cfg.wr_en) begin
        unique case (cfg.idx)
          dsp_pkg::REG_CPI_MIN: cpi_min_r <= cfg.wdata[dsp_pkg::CPI_W-1:0];
          dsp_pkg::REG_CPI_MAX: cpi_max_r <= cfg.wdata[dsp_pkg::CPI_W-1:0];
          dsp_pkg::REG_CPI_DEF: cpi_def_r <= cfg.wdata[dsp_pkg::CPI_W-1:0];
          dsp_pkg::REG_DIV_DEF: div_def_r <= cfg.wdata[dsp_pkg::DIV_W-1:0];
        endcase
      end
      if (cmd.wb_en) begin
        cpi_r   <= cpi_nxt;
        div_r   <= div_nxt;
        inv_r   <= inv_nxt;
        drag_r  <= drag_nxt;
        acc_h_r <= acc_h_nxt;
        acc_v_r <= acc_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)   item_r <= in_data;
    if (cmd.sum_en) begin
      sum_h_r <= sum_h_nxt;
      sum_v_r <= sum_v_nxt;
    end
    if (cmd.wb_en)  out_r <= out_nxt;
  end

  always_comb begin
    unique case (cfg_raddr)
      dsp_pkg::REG_CPI_MIN: cfg_rdata = dsp_pkg::DATA_W'(cpi_min_r);
      dsp_pkg::REG_CPI_MAX: cfg_rdata = dsp_pkg::DATA_W'(cpi_max_r);
      dsp_pkg::REG_CPI_DEF: cfg_rdata = dsp_pkg::DATA_W'(cpi_def_r);
      dsp_pkg::REG_DIV_DEF: cfg_rdata = dsp_pkg::DATA_W'(div_def_r);
    endcase
  end

  // divisor stays in its legal range whatever keys arrive
  `DSP_ASSERT_IMP(a_div_range, clk, rst_n, 1'b1,
                  (div_r >= dsp_pkg::DIV_LO) && (div_r <= dsp_pkg::DIV_HI),
                  "scroll divisor out of range")

endmodule

`default_nettype wire

>>> src/dsp_ctrl.sv
// controller: sequences accept, divide, sum and write-back of one request
// depends on dsp_pkg and the assertion macro header
`default_nettype none
`include "drag_scroll_pointer_processor_macros.svh"

module dsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dsp_pkg::dsp_cmd_t  cmd,
  input  wire dsp_pkg::dsp_sts_t sts
);

  dsp_pkg::dsp_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != dsp_pkg::S_IDLE);
    unique case (state_r)
      dsp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.in_is_key && sts.drag) begin
            cmd.start_div = 1'b1;
            state_nxt     = dsp_pkg::S_DIV;
          end else begin
            state_nxt = dsp_pkg::S_WB;
          end
        end
      end
      dsp_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = dsp_pkg::S_SUM;
      end
      dsp_pkg::S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = dsp_pkg::S_WB;
      end
      dsp_pkg::S_WB: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.wb_en = 1'b1;
          state_nxt = dsp_pkg::S_IDLE;
        end
      end
    endcase
    out_valid_nxt = cmd.wb_en || (out_valid_r && out_stall);
  end

  `DSP_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n,
                  (state_r == dsp_pkg::S_IDLE) && in_valid,
                  state_r != dsp_pkg::S_IDLE, "accepted request left controller idle")
  `DSP_ASSERT_NXT(a_div_wait, clk, rst_n,
                  (state_r == dsp_pkg::S_DIV) && !sts.div_done,
                  state_r == dsp_pkg::S_DIV, "left divide before quotient ready")
  `DSP_ASSERT_NXT(a_wb_shows_result, clk, rst_n, cmd.wb_en, out_valid_r,
                  "write-back did not raise out_valid")

endmodule

`default_nettype wire

>>> src/drag_scroll_pointer_processor.sv
// key events and plain motion go from accept straight to write-back, then out_valid;
// drag motion goes accept, divide, sum, write-back; one request is in flight at a time
// the drag path is paced by the serial restoring dividers, one quotient bit per cycle
// a new request is taken while a finished result still waits in the output register
// reset is synchronous, active low: registers to defaults, cpi 400, divisor 5,
// invert on, drag off, accumulators zero; no clearing pass
`default_nettype none

module drag_scroll_pointer_processor #(
  parameter int FRAC_BITS = dsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire dsp_pkg::dsp_in_t             in_data,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output dsp_pkg::dsp_out_t                 out_data,
  // apb-style register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dsp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dsp_pkg::DATA_W-1:0]   pwdata,
  output logic [dsp_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  dsp_pkg::dsp_cmd_t cmd;
  dsp_pkg::dsp_sts_t sts;
  dsp_pkg::dsp_cfg_t cfg;
  dsp_pkg::dsp_reg_t reg_sel;

  // registers sit on word addresses, low address bits ignored
  assign reg_sel   = dsp_pkg::dsp_reg_t'(paddr[3:2]);
  assign pready    = 1'b1;
  // write lands in the access phase
  assign cfg.wr_en = psel && penable && pwrite;
  assign cfg.idx   = reg_sel;
  assign cfg.wdata = pwdata;

  // sequencer: idle, divide, sum, write-back
  dsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // state, accumulators, dividers and the result register
  dsp_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg       (cfg),
    .cfg_raddr (reg_sel),
    .cfg_rdata (prdata)
  );

endmodule

`default_nettype wire
